// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;

   localparam logic [CELL_W-1:0] ATTR_MASK  = 16'hFF00;
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

   // request kinds (tuser bit 0)
   localparam logic ACTION_PUT  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // cursor step command
   typedef struct packed {
      logic step;      // advance the cursor for one put
      logic newline;   // the put is a newline
   } cur_cmd_type;

endpackage

// File: rtl/tcw_cell_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_cell_ram
// Cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcw_pkg::CELL_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0] wr_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tcw_cursor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_cursor
// Cursor column, row and linear cell address; flags a step that blanks.
// ---------------------------------------------------------------------------
module tcw_cursor #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int COL_W   = 7,
   parameter int ROW_W   = 5,
   parameter int ADDR_W  = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_pkg::cur_cmd_type cmd,
   output logic [COL_W-1:0]     col,
   output logic [ROW_W-1:0]     row,
   output logic [ADDR_W-1:0]    addr,
   output logic                 clear_next   // this command would blank the screen
);
   import tcw_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   logic [COL_W:0]  col_inc;
   logic [ROW_W:0]  row_inc;
   logic [ADDR_W:0] addr_next_row;
   logic            wrap;

   always_comb begin
      col_inc       = {1'b0, col_ff} + (COL_W+1)'(1);
      row_inc       = {1'b0, row_ff} + (ROW_W+1)'(1);
      addr_next_row = {1'b0, addr_ff} - (ADDR_W+1)'(col_ff) + (ADDR_W+1)'(COLUMNS);
      wrap          = cmd.newline || (col_inc == (COL_W+1)'(COLUMNS));
      clear_next    = wrap && (row_inc == (ROW_W+1)'(ROWS));

      col_in  = col_ff;
      row_in  = row_ff;
      addr_in = addr_ff;
      if (cmd.step) begin
         priority if (clear_next) begin
            col_in  = '0;
            row_in  = '0;
            addr_in = '0;
         end else if (wrap) begin
            col_in  = '0;
            row_in  = row_inc[ROW_W-1:0];
            addr_in = addr_next_row[ADDR_W-1:0];
         end else begin
            col_in  = col_inc[COL_W-1:0];
            addr_in = addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         addr_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         addr_ff <= addr_in;
      end
   end

   assign col  = col_ff;
   assign row  = row_ff;
   assign addr = addr_ff;

endmodule

// File: rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: cell store with cursor, character puts and cell reads.
// ---------------------------------------------------------------------------
// The screen is COLUMNS x ROWS cells of 16 bits (attribute high byte,
// character low byte) held in one synchronous RAM. Requests are taken one at
// a time: a read goes from the RAM read through the data state to the
// result register; a character put reads the cell, then writes it back with
// the attribute kept; a newline goes straight to the hand-off. A put that
// steps past the last row also sweeps the whole RAM, one cell per cycle,
// rewriting every character as a space; no request is taken meanwhile. After
// reset the same sweep loads every cell with 0x0720, with req_tready low. The
// result register decouples the two sides: the next request is taken while
// a result still waits for rsp_tready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer_core #(
   parameter int COLUMNS = 80,   // 2 .. 128
   parameter int ROWS    = 25    // 2 .. 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [18:8] cell_index, [23:19] zero
   input  logic [0:0]  req_tuser,   // [0] action (0 put, 1 read)
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] cell_value, [22:16] cursor_column,
                                    // [27:23] cursor_line, [28] screen_cleared,
                                    // [31:29] zero
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);

   // controller states
   localparam logic [2:0] S_IDLE  = 3'd0;   // waiting for a request
   localparam logic [2:0] S_RDATA = 3'd1;   // read data back from the RAM
   localparam logic [2:0] S_PUTWR = 3'd2;   // write back the put cell
   localparam logic [2:0] S_SWEEP = 3'd3;   // init / blanking pass
   localparam logic [2:0] S_RESP  = 3'd4;   // hand result to output register

   // request fields
   logic [CHAR_W-1:0] req_char;
   logic [10:0]       req_index;
   logic              req_action;
   logic [ADDR_W+10:0] req_index_ext;

   assign req_char      = req_tdata[7:0];
   assign req_index     = req_tdata[18:8];
   assign req_action    = req_tuser[0];
   assign req_index_ext = {{ADDR_W{1'b0}}, req_index};

   // control state
   logic [2:0]       state_ff, state_in;
   logic             init_ff, init_in;      // sweep loads reset value
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // current request
   logic [ADDR_W-1:0] op_addr_ff, op_addr_in;
   logic [CHAR_W-1:0] op_char_ff, op_char_in;
   logic              op_hit_ff, op_hit_in;     // read index in range
   logic              op_clear_ff, op_clear_in; // put blanks the screen
   logic [CELL_W-1:0] pend_value_ff, pend_value_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic [4:0]        rsp_line_ff, rsp_line_in;
   logic              rsp_clear_ff, rsp_clear_in;

   // RAM ports
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [CELL_W-1:0] rd_data, wr_data;

   // cursor
   cur_cmd_type       cur_cmd;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [ADDR_W-1:0] cur_addr;
   logic              cur_clear_next;
   logic [COL_W+6:0]  cur_col_ext;
   logic [ROW_W+4:0]  cur_row_ext;

   logic             accept;
   logic             in_range;
   logic             is_newline;
   logic             rsp_free;
   logic             sweep_end;
   logic [CNT_W-1:0] cnt_dec;

   assign cur_col_ext = {7'd0, cur_col};
   assign cur_row_ext = {5'd0, cur_row};

   tcw_cell_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .COL_W   (COL_W),
      .ROW_W   (ROW_W),
      .ADDR_W  (ADDR_W)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cur_cmd),
      .col        (cur_col),
      .row        (cur_row),
      .addr       (cur_addr),
      .clear_next (cur_clear_next)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = (32'(req_index) < 32'(CELL_COUNT));
   assign is_newline = (req_char == NEWLINE_CODE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign sweep_end  = (cnt_ff == CNT_W'(CELL_COUNT));
   assign cnt_dec    = cnt_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      cnt_in        = cnt_ff;
      op_addr_in    = op_addr_ff;
      op_char_in    = op_char_ff;
      op_hit_in     = op_hit_ff;
      op_clear_in   = op_clear_ff;
      pend_value_in = pend_value_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_line_in   = rsp_line_ff;
      rsp_clear_in  = rsp_clear_ff;

      cur_cmd.step    = 1'b0;
      cur_cmd.newline = is_newline;

      rd_en   = 1'b0;
      rd_addr = cur_addr;
      wr_en   = 1'b0;
      wr_addr = op_addr_ff;
      wr_data = (rd_data & ATTR_MASK) | {8'd0, op_char_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_char_in    = req_char;
               pend_value_in = '0;
               if (req_action == ACTION_READ) begin
                  rd_en       = 1'b1;
                  rd_addr     = req_index_ext[ADDR_W-1:0];
                  op_hit_in   = in_range;
                  op_clear_in = 1'b0;
                  state_in    = S_RDATA;
               end else begin
                  cur_cmd.step = 1'b1;
                  op_addr_in   = cur_addr;
                  op_clear_in  = cur_clear_next;
                  op_hit_in    = 1'b0;
                  priority if (!is_newline) begin
                     rd_en    = 1'b1;
                     state_in = S_PUTWR;
                  end else if (cur_clear_next) begin
                     init_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = S_SWEEP;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         S_RDATA: begin
            pend_value_in = op_hit_ff ? rd_data : '0;
            state_in      = S_RESP;
         end
         S_PUTWR: begin
            wr_en = 1'b1;
            if (op_clear_ff) begin
               init_in  = 1'b0;
               cnt_in   = '0;
               state_in = S_SWEEP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SWEEP: begin
            // read cell cnt, write back cell cnt-1 from last cycle's read
            rd_en   = !sweep_end;
            rd_addr = cnt_ff[ADDR_W-1:0];
            wr_en   = (cnt_ff != '0);
            wr_addr = cnt_dec[ADDR_W-1:0];
            wr_data = init_ff ? RESET_CELL : ((rd_data & ATTR_MASK) | {8'd0, SPACE_CODE});
            if (sweep_end) begin
               cnt_in   = '0;
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_RESP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_col_in   = cur_col_ext[6:0];
               rsp_line_in  = cur_row_ext[4:0];
               rsp_clear_in = op_clear_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         init_ff      <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         op_clear_ff  <= 1'b0;
         op_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         op_clear_ff  <= op_clear_in;
         op_hit_ff    <= op_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_addr_ff    <= op_addr_in;
      op_char_ff    <= op_char_in;
      pend_value_ff <= pend_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_clear_ff  <= rsp_clear_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_clear_ff, rsp_line_ff, rsp_col_ff, rsp_value_ff};

   // a blanking result always reports the cursor at home and no cell value
   `ASSERT_IMPLIES(a_clear_homes, clock, reset, rsp_valid_ff && rsp_clear_ff,
      rsp_col_ff == 7'd0 && rsp_line_ff == 5'd0 && rsp_value_ff == '0)
   // the cursor never leaves the screen
   `ASSERT_IMPLIES(a_cursor_bounds, clock, reset, 1'b1,
      32'(cur_col) < 32'(COLUMNS) && 32'(cur_row) < 32'(ROWS))
   // a new result is only loaded from the hand-off state
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_RESP)
   // a put that blanks always goes through the sweep
   `ASSERT_NEXT(a_clear_sweeps, clock, reset,
      state_ff == S_PUTWR && op_clear_ff, state_ff == S_SWEEP && !init_ff)

endmodule

// File: test/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console writer.
// ---------------------------------------------------------------------------
// A shadow copy of the screen and cursor predicts every response. A short
// directed part covers field extremes and reads at and past the last cell.
// It is followed by random segments: lines of text, newline runs, fills that
// end in a newline or a wrap on the last row, cell reads and raw noise.
// The sender runs in bursts with gaps, and the receiver stalls on its own
// changing pattern.
// ---------------------------------------------------------------------------
module tb_text_console_writer_core;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int INDEX_MAX = 2047;          // full reach of cell_index
   localparam int RANDOM_ITEMS = 650;
   // a clear sweeps every cell, so allow a few sweeps of silence
   localparam int WATCHDOG_LIMIT = 4 * (CELLS + 1) + 1000;
   localparam int SETTLE_CYCLES  = CELLS + 100;

   // one predicted response, with the field widths of rsp_tdata
   typedef struct packed {
      logic [15:0] cell_value;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_line;
      logic        screen_cleared;
   } console_rsp_type;

   typedef enum int {
      SEG_TEXT,
      SEG_READS,
      SEG_NEWLINES,
      SEG_FILL_WRAP,
      SEG_FILL_NEWLINE,
      SEG_NOISE,
      SEG_DRAIN
   } segment_kind_type;

   // -------------------------------------------------------------------------
   // Screen shadow: holds the cells and cursor, predicts each response and
   // compares it with what the block returns.
   // -------------------------------------------------------------------------
   class screen_shadow;
      logic [15:0]     cells [CELLS];
      int unsigned     cur_col;
      int unsigned     cur_row;
      console_rsp_type outcome_q [$];
      int              errors;

      function new();
         for (int i = 0; i < CELLS; i++)
            cells[i] = RESET_CELL;
         cur_col = 0;
         cur_row = 0;
         errors  = 0;
      endfunction

      // one accepted request: update the shadow, queue the response
      function void apply_request(logic act, logic [7:0] ch, logic [10:0] idx);
         console_rsp_type r;
         int unsigned     at;
         r = '0;
         if (act == ACTION_READ) begin
            if (idx < CELLS)
               r.cell_value = cells[idx];
         end else begin
            if (ch == NEWLINE_CODE) begin
               cur_row++;
               cur_col = 0;
            end else begin
               at = cur_row * COLUMNS + cur_col;
               if (at < CELLS)
                  cells[at] = (cells[at] & ATTR_MASK) | {8'h00, ch};
               cur_col++;
            end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= ROWS) begin
               // blank every character, attributes stay
               for (int i = 0; i < CELLS; i++)
                  cells[i] = (cells[i] & ATTR_MASK) | {8'h00, SPACE_CODE};
               cur_col = 0;
               cur_row = 0;
               r.screen_cleared = 1'b1;
            end
         end
         r.cursor_column = 7'(cur_col);
         r.cursor_line   = 5'(cur_row);
         outcome_q.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
         $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                  want, got);
         errors++;
      endtask

      task compare_response(logic [31:0] d);
         console_rsp_type want;
         if (outcome_q.size() == 0) begin
            report_mismatch("response with no request pending", '0, d);
            return;
         end
         want = outcome_q.pop_front();
         if (d[15:0] !== want.cell_value)
            report_mismatch("cell_value", want.cell_value, d[15:0]);
         if (d[22:16] !== want.cursor_column)
            report_mismatch("cursor_column", want.cursor_column, d[22:16]);
         if (d[27:23] !== want.cursor_line)
            report_mismatch("cursor_line", want.cursor_line, d[27:23]);
         if (d[28] !== want.screen_cleared)
            report_mismatch("screen_cleared", want.screen_cleared, d[28]);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals; every input is known from time zero
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // [7:0] char_code, [18:8] cell_index, [23:19] zero
   logic [0:0]  req_tuser  = '0;    // [0] action (0 put, 1 read)
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [15:0] cell_value, [22:16] cursor_column,
                                    // [27:23] cursor_line, [28] screen_cleared

   screen_shadow sb = new();

   int burst_left = 0;     // requests left in the current sender burst
   int random_sent = 0;    // random-phase requests accepted
   int idle_cycles = 0;    // watchdog: cycles with no handshake on either side

   // rsp_tready pattern state
   logic [7:0] rx_phase = '0;
   logic [1:0] rx_mode  = '0;
   int         rx_hold  = 0;

   text_console_writer_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Receiver: a new random mode is picked whenever rx_phase[6:0] is zero. Modes:
   // always ready, coin flip, one cycle in four, and long random stalls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rx_phase <= rx_phase + 8'd1;
      if (rx_phase[6:0] == 7'd0)
         rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (rx_phase[1:0] == 2'd3);
         default: begin
            if (rx_hold > 0) begin
               rx_hold    <= rx_hold - 1;
               rsp_tready <= 1'b0;
            end else begin
               rx_hold    <= $urandom_range(0, 24);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // check every response the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.compare_response(rsp_tdata);
   end

   // watchdog: silence longer than a few screen sweeps means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("text_console_writer_core verification failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   // Drive one request and hold it until accepted. A new burst starts with a
   // random gap (sometimes none). valid stays high between requests of a burst.
   task automatic push_request(logic act, logic [7:0] ch, logic [10:0] idx);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, idx, ch};
      req_tuser  <= act;
      do
         @(posedge clock);
      while (!req_tready);
      sb.apply_request(act, ch, idx);
   endtask

   // any byte but newline
   function automatic logic [7:0] pick_glyph();
      logic [7:0] ch;
      do
         ch = 8'($urandom_range(0, 255));
      while (ch == NEWLINE_CODE);
      return ch;
   endfunction

   task automatic put_char(logic [7:0] ch);
      push_request(ACTION_PUT, ch, 11'($urandom_range(0, INDEX_MAX)));
   endtask

   task automatic read_cell(int idx);
      push_request(ACTION_READ, 8'($urandom_range(0, 255)), 11'(idx));
   endtask

   // reads mostly land in the area written since the last clear
   task automatic read_near_cursor();
      int upper;
      if ($urandom_range(0, 3) == 0) begin
         read_cell($urandom_range(0, INDEX_MAX));
      end else begin
         upper = sb.cur_row * COLUMNS + sb.cur_col + COLUMNS;
         if (upper > INDEX_MAX)
            upper = INDEX_MAX;
         read_cell($urandom_range(0, upper));
      end
   endtask

   // hold off until every queued response has come back
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do
         @(posedge clock);
      while (sb.outcome_q.size() != 0);
   endtask

   task automatic run_segment(segment_kind_type kind);
      int n;
      case (kind)
         SEG_TEXT: begin
            n = $urandom_range(1, 90);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 11) == 0)
                  put_char(NEWLINE_CODE);
               else if ($urandom_range(0, 9) == 0)
                  read_near_cursor();
               else
                  put_char(pick_glyph());
            end
            random_sent += n;
         end
         SEG_READS: begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
               read_near_cursor();
            random_sent += n;
         end
         SEG_NEWLINES: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               put_char(NEWLINE_CODE);
            random_sent += n;
         end
         SEG_FILL_WRAP: begin
            // walk to the last cell, then one more char wraps past the last row
            while (sb.cur_row < ROWS - 1) begin
               put_char(NEWLINE_CODE);
               random_sent++;
            end
            while (sb.cur_col < COLUMNS - 1) begin
               put_char(pick_glyph());
               random_sent++;
            end
            put_char(pick_glyph());
            random_sent++;
         end
         SEG_FILL_NEWLINE: begin
            // newline issued on the last row
            while (sb.cur_row < ROWS - 1) begin
               if ($urandom_range(0, 2) == 0)
                  put_char(pick_glyph());
               else
                  put_char(NEWLINE_CODE);
               random_sent++;
            end
            put_char(NEWLINE_CODE);
            random_sent++;
         end
         SEG_NOISE: begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
               push_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, INDEX_MAX)));
            random_sent += n;
         end
         default: wait_for_quiet();
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int               seg;
      int               pick;
      segment_kind_type kind;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reads at the ends and past the last cell, char extremes
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell(INDEX_MAX);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h41);
      read_cell(0);
      read_cell(1);
      read_cell(2);
      put_char(NEWLINE_CODE);
      put_char(8'h7F);
      put_char(8'h80);
      read_cell(COLUMNS);
      read_cell(COLUMNS + 1);
      put_char(8'hAA);
      put_char(8'h55);
      read_cell(11'h555);
      read_cell(11'h2AA);
      push_request(ACTION_READ, 8'hFF, 11'h7FF);
      wait_for_quiet();

      // random segments; the last-row cases and a pause are forced early
      seg = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (seg == 0)
            kind = SEG_FILL_NEWLINE;
         else if (seg == 1)
            kind = SEG_FILL_WRAP;
         else if (seg == 4)
            kind = SEG_DRAIN;
         else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               kind = SEG_TEXT;
            else if (pick < 65)
               kind = SEG_READS;
            else if (pick < 75)
               kind = SEG_NEWLINES;
            else if (pick < 81)
               kind = SEG_FILL_WRAP;
            else if (pick < 87)
               kind = SEG_FILL_NEWLINE;
            else if (pick < 95)
               kind = SEG_NOISE;
            else
               kind = SEG_DRAIN;
         end
         run_segment(kind);
         seg++;
      end

      // drain, then give a possible clear sweep time to finish
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.outcome_q.size() != 0)
         sb.report_mismatch("responses still pending", '0, sb.outcome_q.size());

      if (sb.errors == 0)
         $display("text_console_writer_core verification clean");
      else
         $display("text_console_writer_core verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_cursor.sv
rtl/text_console_writer_core.sv
test/tb_text_console_writer_core.sv
